// ===== rtl/core/gtsa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gtsa_pkg;

   localparam int SLOT_COUNT  = 1024;
   localparam int SLOT_W      = $clog2(SLOT_COUNT);
   localparam int PAGE_BYTES  = 4096;
   localparam int PAGE_BITS   = $clog2(PAGE_BYTES);
   // a slot is a writable page plus a guard page
   localparam int STRIDE_BITS = PAGE_BITS + 1;
   localparam int ADDR_W      = 48;
   localparam int SIZE_W      = 16;
   localparam int COUNT_W     = $clog2(SLOT_COUNT + 1);

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // classified request, as it travels from the front to the back
   typedef struct packed {
      logic                 is_free;
      logic                 valid;    // size or address passed its checks
      logic [SLOT_W-1:0]    slot;     // decoded slot of a free
      logic [PAGE_BITS-1:0] size;     // bytes wanted, or size implied by a free
   } job_type;

endpackage

`default_nettype wire

// ===== rtl/core/gtsa_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface gtsa_req_if
   import gtsa_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              command;
   logic [SIZE_W-1:0] request_size;
   logic [ADDR_W-1:0] free_address;

   modport source (output valid, output command, output request_size,
                   output free_address, input ready);
   modport sink   (input valid, input command, input request_size,
                   input free_address, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gtsa_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface gtsa_rsp_if
   import gtsa_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               ok;
   logic [ADDR_W-1:0]  user_address;
   logic [COUNT_W-1:0] free_count;
   logic [COUNT_W-1:0] used_count;

   modport source (output valid, output ok, output user_address, output free_count,
                   output used_count, input ready);
   modport sink   (input valid, input ok, input user_address, input free_count,
                   input used_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gtsa_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gtsa_front
   import gtsa_pkg::*;
(
   gtsa_req_if.sink          req_chan,
   input  wire logic [ADDR_W-1:0] region_base,
   input  wire logic         clearing,
   input  wire logic         q_full,
   output logic              q_push,
   output job_type           q_job
);

   logic [ADDR_W-1:0]      offset;
   logic [STRIDE_BITS-1:0] slot_offs;
   logic                   dec_ok;

   assign req_chan.ready = !clearing && !q_full;
   assign q_push         = req_chan.valid && req_chan.ready;

   // offset into the region wraps modulo the address space
   assign offset    = req_chan.free_address - region_base;
   assign slot_offs = offset[STRIDE_BITS-1:0];
   assign dec_ok    = (offset[ADDR_W-1:STRIDE_BITS+SLOT_W] == '0)
                      && (slot_offs != '0)
                      && (slot_offs <= STRIDE_BITS'(PAGE_BYTES));

   always_comb begin
      q_job.is_free = (req_chan.command == CMD_FREE);
      if (req_chan.command == CMD_FREE) begin
         q_job.valid = dec_ok;
         q_job.slot  = offset[STRIDE_BITS+SLOT_W-1:STRIDE_BITS];
         q_job.size  = PAGE_BITS'(STRIDE_BITS'(PAGE_BYTES) - slot_offs);
      end else begin
         q_job.valid = (req_chan.request_size < SIZE_W'(PAGE_BYTES));
         q_job.slot  = '0;
         q_job.size  = req_chan.request_size[PAGE_BITS-1:0];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/gtsa_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gtsa_queue
   import gtsa_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   input  wire logic    pop,
   output logic         pop_valid,
   output job_type      pop_job
);

   job_type    entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == 2'd2);
   assign pop_valid = (cnt_ff != 2'd0);
   assign pop_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop)
         cnt_in = cnt_ff + 2'd1;
      else if (pop && !push)
         cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (push)
            wr_ptr_ff <= !wr_ptr_ff;
         if (pop)
            rd_ptr_ff <= !rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         entry_ff[wr_ptr_ff] <= push_job;
   end

endmodule

`default_nettype wire

// ===== rtl/core/gtsa_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gtsa_back
   import gtsa_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [ADDR_W-1:0] region_base,
   input  wire logic         q_valid,
   input  wire job_type      q_job,
   output logic              q_pop,
   output logic              clearing,
   gtsa_rsp_if.source        rsp_chan
);

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EXEC} state_type;

   state_type          state_ff;
   logic [SLOT_W-1:0]  clr_idx_ff;
   logic [SLOT_W-1:0]  head_ff, tail_ff;
   logic               wrapped_ff;     // tail has gone round the ring once
   logic [COUNT_W-1:0] count_ff, count_in;
   job_type            job_ff;
   logic               ident_ff;       // head entry never written: holds its own index

   logic               rsp_valid_ff, rsp_ok_ff;
   logic [ADDR_W-1:0]  rsp_addr_ff;
   logic [COUNT_W-1:0] rsp_free_ff, rsp_used_ff;

   // free ring and slot table {in_use, size}
   logic [SLOT_W-1:0]    ring_mem [SLOT_COUNT];
   logic [PAGE_BITS:0]   tab_mem  [SLOT_COUNT];
   logic [SLOT_W-1:0]    ring_rd_ff;
   logic [PAGE_BITS:0]   tab_rd_ff;

   logic               can_out, commit, alloc_go, free_go;
   logic [SLOT_W-1:0]  alloc_slot;
   logic [ADDR_W-1:0]  alloc_addr;
   logic               tab_we, ring_we;
   logic [SLOT_W-1:0]  tab_waddr;
   logic [PAGE_BITS:0] tab_wdata;

   assign clearing = (state_ff == ST_CLEAR);
   assign q_pop    = (state_ff == ST_IDLE) && q_valid;
   assign can_out  = !rsp_valid_ff || rsp_chan.ready;
   assign commit   = (state_ff == ST_EXEC) && can_out;

   assign alloc_slot = ident_ff ? head_ff : ring_rd_ff;
   assign alloc_go   = !job_ff.is_free && job_ff.valid && (count_ff != '0);
   assign free_go    = job_ff.is_free && job_ff.valid && tab_rd_ff[PAGE_BITS]
                       && (tab_rd_ff[PAGE_BITS-1:0] == job_ff.size)
                       && (count_ff != COUNT_W'(SLOT_COUNT));
   // buffer ends right where the guard page starts
   assign alloc_addr = region_base
                       + ADDR_W'({alloc_slot, STRIDE_BITS'(PAGE_BYTES - int'(job_ff.size))});

   always_comb begin
      count_in = count_ff;
      if (alloc_go)
         count_in = count_ff - COUNT_W'(1);
      else if (free_go)
         count_in = count_ff + COUNT_W'(1);
   end

   always_comb begin
      tab_we    = 1'b0;
      tab_waddr = job_ff.slot;
      tab_wdata = {1'b0, job_ff.size};
      if (state_ff == ST_CLEAR) begin
         tab_we    = 1'b1;
         tab_waddr = clr_idx_ff;
         tab_wdata = '0;
      end else if (commit && alloc_go) begin
         tab_we    = 1'b1;
         tab_waddr = alloc_slot;
         tab_wdata = {1'b1, job_ff.size};
      end else if (commit && free_go) begin
         tab_we    = 1'b1;
      end
   end

   assign ring_we = commit && free_go;

   always_ff @(posedge clock) begin
      if (ring_we)
         ring_mem[tail_ff] <= job_ff.slot;
      if (q_pop)
         ring_rd_ff <= ring_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (tab_we)
         tab_mem[tab_waddr] <= tab_wdata;
      if (q_pop)
         tab_rd_ff <= tab_mem[q_job.slot];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         wrapped_ff   <= 1'b0;
         count_ff     <= COUNT_W'(SLOT_COUNT);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready && !commit)
            rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               clr_idx_ff <= clr_idx_ff + SLOT_W'(1);
               if (clr_idx_ff == SLOT_W'(SLOT_COUNT - 1))
                  state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (q_valid) begin
                  job_ff   <= q_job;
                  ident_ff <= !wrapped_ff && (head_ff >= tail_ff);
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (can_out) begin
                  count_ff <= count_in;
                  if (alloc_go)
                     head_ff <= (head_ff == SLOT_W'(SLOT_COUNT - 1)) ? '0
                                : head_ff + SLOT_W'(1);
                  if (free_go) begin
                     tail_ff <= (tail_ff == SLOT_W'(SLOT_COUNT - 1)) ? '0
                                : tail_ff + SLOT_W'(1);
                     if (tail_ff == SLOT_W'(SLOT_COUNT - 1))
                        wrapped_ff <= 1'b1;
                  end
                  rsp_valid_ff <= 1'b1;
                  rsp_ok_ff    <= alloc_go || free_go;
                  rsp_addr_ff  <= alloc_go ? alloc_addr : '0;
                  rsp_free_ff  <= count_in;
                  rsp_used_ff  <= COUNT_W'(SLOT_COUNT) - count_in;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_CLEAR;
         endcase
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.ok           = rsp_ok_ff;
   assign rsp_chan.user_address = rsp_addr_ff;
   assign rsp_chan.free_count   = rsp_free_ff;
   assign rsp_chan.used_count   = rsp_used_ff;

endmodule

`default_nettype wire

// ===== rtl/core/guard_tail_slot_allocator.sv =====
// Guard-tail slot allocator: hands out fixed slots of a pool, each a writable
// page followed by a guard page, and takes them back.
// Channels: req_chan carries a request (allocate with a size, or free with an
// address); rsp_chan returns one result per request: ok, the buffer address
// on a successful allocate, and the free and used slot counts after it.
// csr_we/csr_wdata write region_base; write it only while no request is in
// flight.
// Path: queue register, then the execution unit's IDLE and EXEC states; the
// result is registered. The unit takes no new request until done with the
// last: it reads the free ring and slot table memories in IDLE and writes
// them in EXEC. A two-entry queue between the front and the execution unit
// takes requests meanwhile. Reset: a pass clears the slot table, and
// req_chan.ready stays low until done; the free ring needs no pass.
// Receiver stall: the result is held in the output register; the execution
// unit waits on it and the queue then fills, after which req_chan.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module guard_tail_slot_allocator
   import gtsa_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   gtsa_req_if.sink               req_chan,
   gtsa_rsp_if.source             rsp_chan,
   input  wire logic              csr_we,
   input  wire logic [ADDR_W-1:0] csr_wdata
);

   logic [ADDR_W-1:0] region_base_ff;
   logic              clearing, q_full, q_push, q_pop, q_valid;
   job_type           push_job, pop_job;

   always_ff @(posedge clock) begin
      if (reset)
         region_base_ff <= '0;
      else if (csr_we)
         region_base_ff <= csr_wdata;
   end

   gtsa_front u_front (
      .req_chan    (req_chan),
      .region_base (region_base_ff),
      .clearing    (clearing),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_job       (push_job)
   );

   gtsa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (push_job),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_job   (pop_job)
   );

   gtsa_back u_back (
      .clock       (clock),
      .reset       (reset),
      .region_base (region_base_ff),
      .q_valid     (q_valid),
      .q_job       (pop_job),
      .q_pop       (q_pop),
      .clearing    (clearing),
      .rsp_chan    (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== rtl/core/gtsa_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gtsa_checker
   import gtsa_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic               rsp_ok,
   input wire logic [ADDR_W-1:0]  rsp_user_address,
   input wire logic [COUNT_W-1:0] rsp_free_count,
   input wire logic [COUNT_W-1:0] rsp_used_count
);

   // every slot is either in the ring or in use
   a_counts_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_free_count + rsp_used_count) == COUNT_W'(SLOT_COUNT))
      else $error("free and used counts do not cover the pool");

   a_fail_no_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_user_address == '0))
      else $error("failed request returned an address");

   // slot table clearing keeps requests out just after reset
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("request taken before the slot table was cleared");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_ok)
         && $stable(rsp_user_address) && $stable(rsp_free_count)))
      else $error("stalled result changed");

endmodule

bind guard_tail_slot_allocator gtsa_checker u_gtsa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_ok           (rsp_chan.ok),
   .rsp_user_address (rsp_chan.user_address),
   .rsp_free_count   (rsp_chan.free_count),
   .rsp_used_count   (rsp_chan.used_count)
);

`default_nettype wire

// ===== tb/sv/guard_tail_slot_allocator_test.sv =====
`timescale 1ns / 1ps

module guard_tail_slot_allocator_test;
   import gtsa_pkg::*;

   localparam int STRIDE          = 2 * PAGE_BYTES;
   localparam int WATCHDOG_CYCLES = 4000;
   localparam int PRED_DEPTH      = 16;

   typedef struct packed {
      logic               ok;
      logic [ADDR_W-1:0]  user_address;
      logic [COUNT_W-1:0] free_count;
      logic [COUNT_W-1:0] used_count;
   } slot_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_we;
   logic [ADDR_W-1:0] csr_wdata;

   gtsa_req_if req_chan ();
   gtsa_rsp_if rsp_chan ();

   guard_tail_slot_allocator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // mirror of the allocator
   logic [SLOT_W-1:0]    ring_slots [SLOT_COUNT];
   int                   ring_rd;
   int                   ring_wr;
   int                   ring_fill;
   bit                   slot_live  [SLOT_COUNT];
   logic [PAGE_BITS-1:0] slot_bytes [SLOT_COUNT];
   logic [ADDR_W-1:0]    base_addr;
   int                   live_slots [SLOT_COUNT];
   int                   live_total = 0;
   logic [ADDR_W-1:0]    last_freed_addr;

   // expected results in order, as a small ring
   slot_result_type predicted_results [PRED_DEPTH];
   int              pred_rd = 0;
   int              pred_wr = 0;
   int              pred_count = 0;
   int              mismatch_count = 0;
   bit              idling_on = 1'b1;

   function automatic logic [ADDR_W-1:0] rand_addr();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[ADDR_W-1:0];
   endfunction

   // mostly short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idling_on || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [ADDR_W-1:0] live_address(int s);
      return base_addr + (ADDR_W'(s) << STRIDE_BITS) + ADDR_W'(PAGE_BYTES)
             - ADDR_W'(slot_bytes[s]);
   endfunction

   function automatic void clear_slot_mirror();
      for (int i = 0; i < SLOT_COUNT; i++) begin
         ring_slots[i] = SLOT_W'(i);
         slot_live[i]  = 1'b0;
         slot_bytes[i] = '0;
      end
      ring_rd   = 0;
      ring_wr   = 0;
      ring_fill = SLOT_COUNT;
      base_addr = '0;
      live_total = 0;
      last_freed_addr = '0;
   endfunction

   function automatic void add_expected(slot_result_type r);
      predicted_results[pred_wr] = r;
      pred_wr = (pred_wr + 1) % PRED_DEPTH;
      pred_count++;
   endfunction

   function automatic void drop_live_slot(int s);
      for (int i = 0; i < live_total; i++) begin
         if (live_slots[i] == s) begin
            live_slots[i] = live_slots[live_total - 1];
            live_total--;
            break;
         end
      end
   endfunction

   function automatic void apply_request(logic cmd, logic [SIZE_W-1:0] size,
                                         logic [ADDR_W-1:0] addr);
      slot_result_type        r;
      logic [ADDR_W-1:0]      off;
      logic [ADDR_W-1:0]      slot_part;
      logic [STRIDE_BITS-1:0] slot_offs;
      int                     s;
      r = '0;
      if (cmd == CMD_ALLOC) begin
         if (ring_fill > 0 && size < PAGE_BYTES) begin
            s = ring_slots[ring_rd];
            ring_rd = (ring_rd + 1) % SLOT_COUNT;
            ring_fill--;
            slot_live[s]  = 1'b1;
            slot_bytes[s] = size[PAGE_BITS-1:0];
            r.user_address = live_address(s);
            r.ok = 1'b1;
            live_slots[live_total] = s;
            live_total++;
         end
      end else begin
         off       = addr - base_addr;
         slot_part = off >> STRIDE_BITS;
         slot_offs = off[STRIDE_BITS-1:0];
         if (slot_part < SLOT_COUNT && slot_offs >= 1 && slot_offs <= PAGE_BYTES) begin
            s = int'(slot_part);
            if (slot_live[s] && int'(slot_bytes[s]) == PAGE_BYTES - int'(slot_offs)
                && ring_fill < SLOT_COUNT) begin
               slot_live[s] = 1'b0;
               ring_slots[ring_wr] = SLOT_W'(s);
               ring_wr = (ring_wr + 1) % SLOT_COUNT;
               ring_fill++;
               r.ok = 1'b1;
               last_freed_addr = addr;
               drop_live_slot(s);
            end
         end
      end
      r.free_count = COUNT_W'(ring_fill);
      r.used_count = COUNT_W'(SLOT_COUNT - ring_fill);
      add_expected(r);
   endfunction

   task automatic send_request(logic cmd, logic [SIZE_W-1:0] size,
                               logic [ADDR_W-1:0] addr);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.command      <= cmd;
      req_chan.request_size <= size;
      req_chan.free_address <= addr;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      apply_request(cmd, size, addr);
   endtask

   task automatic send_alloc(logic [SIZE_W-1:0] size);
      send_request(CMD_ALLOC, size, rand_addr());
   endtask

   task automatic send_free(logic [ADDR_W-1:0] addr);
      send_request(CMD_FREE, SIZE_W'($urandom()), addr);
   endtask

   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pred_count != 0) @(posedge clock);
   endtask

   task automatic write_region_base(logic [ADDR_W-1:0] value);
      wait_for_results();
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      base_addr = value;
   endtask

   function automatic int pick_live_slot();
      return live_slots[$urandom_range(0, live_total - 1)];
   endfunction

   function automatic logic [ADDR_W-1:0] pick_base();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         2: return ADDR_W'(0) - ADDR_W'($urandom_range(1, 8) * STRIDE);
         default: return rand_addr();
      endcase
   endfunction

   task automatic test_allocate_edges();
      send_alloc(16'd0);       // buffer starts at the guard page
      send_alloc(16'd4095);
      send_alloc(16'd4096);    // oversize
      send_alloc(16'hFFFF);
      send_alloc(16'd1);
      send_alloc(16'd2048);
   endtask

   task automatic test_free_edges();
      send_free(live_address(0));
      send_free(live_address(0));                 // double free
      send_free(live_address(1));
      send_free(live_address(2) + 1);             // wrong size
      send_free(live_address(2) - 1);
      send_free(base_addr + ADDR_W'(2 * STRIDE)); // slot start, offset zero
      send_free(base_addr + ADDR_W'(2 * STRIDE + PAGE_BYTES + 1)); // guard page
      send_free(base_addr + ADDR_W'(SLOT_COUNT * STRIDE + PAGE_BYTES - 1));
      send_free('1);
      send_free(live_address(2));
      send_free(live_address(3));
   endtask

   task automatic test_region_base_changes();
      logic [ADDR_W-1:0] old_addr;
      write_region_base('1);
      send_alloc(16'd0);
      send_alloc(16'd100);
      send_alloc(16'd4095);
      send_free(live_address(pick_live_slot()));
      old_addr = live_address(live_slots[0]);
      write_region_base(rand_addr());
      send_free(old_addr);
      while (live_total != 0) send_free(live_address(live_slots[0]));
      // pool straddles the top of the address space
      write_region_base(ADDR_W'(0) - ADDR_W'(2 * STRIDE));
      repeat (4) send_alloc(SIZE_W'($urandom_range(0, PAGE_BYTES - 1)));
      send_free(live_address(pick_live_slot()));
      send_free(live_address(pick_live_slot()));
   endtask

   task automatic send_random_request();
      int r;
      int sub;
      int p_alloc;
      int s;
      r = $urandom_range(0, 99);
      p_alloc = (live_total > 700) ? 25 : (live_total < 50 ? 75 : 50);
      if (r < p_alloc) begin
         sub = $urandom_range(0, 99);
         if (sub < 85) send_alloc(SIZE_W'($urandom_range(0, PAGE_BYTES - 1)));
         else if (sub < 95) send_alloc(SIZE_W'($urandom_range(PAGE_BYTES, 65535)));
         else send_alloc(sub[0] ? SIZE_W'(0) : SIZE_W'(PAGE_BYTES - 1));
      end else begin
         sub = $urandom_range(0, 99);
         if (live_total > 0 && sub < 75) begin
            send_free(live_address(pick_live_slot()));
         end else if (sub < 85) begin
            send_free(last_freed_addr);
         end else if (live_total > 0 && sub < 95) begin
            s = pick_live_slot();
            case ($urandom_range(0, 2))
               0: send_free(live_address(s) + 1);
               1: send_free(live_address(s) - 1);
               default: send_free(live_address(s) + ADDR_W'(PAGE_BYTES));
            endcase
         end else begin
            send_free(rand_addr());
         end
      end
   endtask

   task automatic test_random_traffic();
      for (int chunk = 0; chunk < 13; chunk++) begin
         idling_on = ($urandom_range(0, 3) != 0);
         repeat (50) send_random_request();
         if (chunk == 4 || $urandom_range(0, 3) == 0) wait_for_results();
         if (chunk % 4 == 3) write_region_base(pick_base());
      end
      idling_on = 1'b1;
   endtask

   task automatic report_field(string name, logic [63:0] exp, logic [63:0] act);
      if (exp !== act) begin
         $display("%0t ns: %s expected 0x%0h actual 0x%0h", $time, name, exp, act);
         mismatch_count++;
      end
   endtask

   // result checker and receiver stalls
   initial begin
      slot_result_type exp;
      int              stall_left;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            if (pred_count == 0) begin
               $display("%0t ns: result expected none actual ok=%0b addr=0x%0h", $time,
                        rsp_chan.ok, rsp_chan.user_address);
               mismatch_count++;
            end else begin
               exp = predicted_results[pred_rd];
               pred_rd = (pred_rd + 1) % PRED_DEPTH;
               pred_count--;
               report_field("ok", 64'(exp.ok), 64'(rsp_chan.ok));
               report_field("user_address", 64'(exp.user_address),
                            64'(rsp_chan.user_address));
               report_field("free_count", 64'(exp.free_count), 64'(rsp_chan.free_count));
               report_field("used_count", 64'(exp.used_count), 64'(rsp_chan.used_count));
            end
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // counts cycles in which neither channel moves anything
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_CYCLES) begin
         @(posedge clock);
         if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1)
             || (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("guard_tail_slot_allocator_test failed");
      $finish;
   end

   initial begin
      req_chan.valid        <= 1'b0;
      req_chan.command      <= CMD_ALLOC;
      req_chan.request_size <= '0;
      req_chan.free_address <= '0;
      csr_we                <= 1'b0;
      csr_wdata             <= '0;
      clear_slot_mirror();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      write_region_base('0);
      test_allocate_edges();
      test_free_edges();
      test_region_base_changes();
      test_random_traffic();
      wait_for_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("guard_tail_slot_allocator_test passed");
      end else begin
         $display("guard_tail_slot_allocator_test failed");
      end
      $finish;
   end

endmodule
